@@ sv/msd_pkg.sv @@
`timescale 1ns / 1ps

package msd_pkg;

    localparam int POS_W   = 21;
    localparam int DIF_W   = 22;
    localparam int PROD_W  = 2 * DIF_W;
    localparam int D2_W    = 46;
    localparam int LEN_W   = 22;
    localparam int SQ_STEPS = D2_W / 2;
    localparam int ROOT_W  = SQ_STEPS;
    localparam int REM_W   = ROOT_W + 1;
    localparam int CNT_W   = $clog2(SQ_STEPS);
    localparam int PC_W    = 4;

    localparam logic [1:0] REG_TICK   = 2'd0;
    localparam logic [1:0] REG_NORMAL = 2'd1;
    localparam logic [1:0] REG_LADDER = 2'd2;
    localparam logic [1:0] REG_RANGE  = 2'd3;

    localparam logic [1:0] AX_NONE = 2'd0;
    localparam logic [1:0] AX_X    = 2'd1;
    localparam logic [1:0] AX_Y    = 2'd2;
    localparam logic [1:0] AX_Z    = 2'd3;

    localparam logic [1:0] MS_NONE  = 2'd0;
    localparam logic [1:0] MS_DIF   = 2'd1;
    localparam logic [1:0] MS_RANGE = 2'd2;
    localparam logic [1:0] MS_LIMIT = 2'd3;

    localparam logic [1:0] AO_HOLD  = 2'd0;
    localparam logic [1:0] AO_CLEAR = 2'd1;
    localparam logic [1:0] AO_ADD   = 2'd2;

    localparam logic [3:0] ACT_NONE    = 4'd0;
    localparam logic [3:0] ACT_START   = 4'd1;
    localparam logic [3:0] ACT_SQ_INIT = 4'd2;
    localparam logic [3:0] ACT_SQ_STEP = 4'd3;
    localparam logic [3:0] ACT_SUB_OLD = 4'd4;
    localparam logic [3:0] ACT_ADD_NEW = 4'd5;
    localparam logic [3:0] ACT_DECIDE  = 4'd6;
    localparam logic [3:0] ACT_UNSTUCK = 4'd7;
    localparam logic [3:0] ACT_CLEAR   = 4'd8;
    localparam logic [3:0] ACT_FINISH  = 4'd9;

    localparam logic [2:0] JC_NEXT   = 3'd0;
    localparam logic [2:0] JC_ALWAYS = 3'd1;
    localparam logic [2:0] JC_CLEAR  = 3'd2;
    localparam logic [2:0] JC_STUCK  = 3'd3;
    localparam logic [2:0] JC_LOOP   = 3'd4;

    localparam logic [PC_W-1:0] PC_START   = 4'd0;
    localparam logic [PC_W-1:0] PC_SQ_LOOP = 4'd6;
    localparam logic [PC_W-1:0] PC_UNSTUCK = 4'd10;
    localparam logic [PC_W-1:0] PC_CLEAR   = 4'd11;
    localparam logic [PC_W-1:0] PC_FINISH  = 4'd12;

    typedef struct packed {
        logic [1:0]      dif_axis;
        logic [1:0]      mul_sel;
        logic [1:0]      acc_op;
        logic [3:0]      act;
        logic [2:0]      jmp_cond;
        logic [PC_W-1:0] jmp_tgt;
    } t_uword;

    function automatic t_uword ucode(input logic [PC_W-1:0] pc);
        t_uword w;
        unique case (pc)
            4'd0:  w = '{AX_X,    MS_NONE,  AO_CLEAR, ACT_START,   JC_CLEAR,  PC_CLEAR};
            4'd1:  w = '{AX_Y,    MS_DIF,   AO_HOLD,  ACT_NONE,    JC_NEXT,   PC_START};
            4'd2:  w = '{AX_Z,    MS_DIF,   AO_ADD,   ACT_NONE,    JC_NEXT,   PC_START};
            4'd3:  w = '{AX_NONE, MS_DIF,   AO_ADD,   ACT_NONE,    JC_NEXT,   PC_START};
            4'd4:  w = '{AX_NONE, MS_RANGE, AO_ADD,   ACT_NONE,    JC_STUCK,  PC_UNSTUCK};
            4'd5:  w = '{AX_NONE, MS_NONE,  AO_HOLD,  ACT_SQ_INIT, JC_NEXT,   PC_START};
            4'd6:  w = '{AX_NONE, MS_NONE,  AO_HOLD,  ACT_SQ_STEP, JC_LOOP,   PC_SQ_LOOP};
            4'd7:  w = '{AX_NONE, MS_LIMIT, AO_HOLD,  ACT_SUB_OLD, JC_NEXT,   PC_START};
            4'd8:  w = '{AX_NONE, MS_NONE,  AO_HOLD,  ACT_ADD_NEW, JC_NEXT,   PC_START};
            4'd9:  w = '{AX_NONE, MS_NONE,  AO_HOLD,  ACT_DECIDE,  JC_ALWAYS, PC_FINISH};
            4'd10: w = '{AX_NONE, MS_NONE,  AO_HOLD,  ACT_UNSTUCK, JC_ALWAYS, PC_FINISH};
            4'd11: w = '{AX_NONE, MS_NONE,  AO_HOLD,  ACT_CLEAR,   JC_NEXT,   PC_START};
            4'd12: w = '{AX_NONE, MS_NONE,  AO_HOLD,  ACT_FINISH,  JC_NEXT,   PC_START};
            default: w = '{AX_NONE, MS_NONE, AO_HOLD, ACT_FINISH,  JC_NEXT,   PC_START};
        endcase
        return w;
    endfunction

endpackage

@@ sv/msd_ram.sv @@
`timescale 1ns / 1ps

module msd_ram #(
    parameter int WIDTH = 22,
    parameter int DEPTH = 8,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/motion_stall_detector_core.sv @@
`timescale 1ns / 1ps

// Channel   | Signals                                        | Transfer when
// ----------+------------------------------------------------+---------------------------
// input     | i_in_valid, o_in_ready, i_pos_*, flags         | i_in_valid && o_in_ready
// output    | o_out_valid, i_out_ready, o_stuck, o_became_*  | o_out_valid && i_out_ready
// config    | psel, penable, pwrite, paddr, pwdata, prdata   | psel && penable && pwrite
//
// A tick that is not stuck runs the 23 passes of the bit-pair square root loop before its
// result is registered; a stuck tick and a clear skip that loop. One tick is in work at a
// time; the next transfer can come in the same cycle that the result turns valid. Reset is
// synchronous and active low; it restores the register defaults and empties the ring. A
// stalled output holds the sequencer in its final step.

module motion_stall_detector_core #(
    parameter int SAMPLE_COUNT = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic signed [msd_pkg::POS_W-1:0]  i_pos_x,
    input  logic signed [msd_pkg::POS_W-1:0]  i_pos_y,
    input  logic signed [msd_pkg::POS_W-1:0]  i_pos_z,
    input  logic                              i_jumping,
    input  logic                              i_on_ladder,
    input  logic                              i_clear_monitor,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_stuck,
    output logic                              o_became_stuck,
    output logic                              o_became_unstuck,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [3:0]                        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    localparam int IDX_W  = $clog2(SAMPLE_COUNT);
    localparam int FILL_W = $clog2(SAMPLE_COUNT + 1);
    localparam int SUM_W  = msd_pkg::LEN_W + $clog2(SAMPLE_COUNT);
    localparam int THR_W  = 16 + $clog2(SAMPLE_COUNT + 1);
    localparam int CMP_W  = (SUM_W > THR_W) ? SUM_W : THR_W;

    logic [7:0] r_tick;
    logic [7:0] r_lim_normal;
    logic [7:0] r_lim_ladder;
    logic [9:0] r_range;

    logic                          r_busy;
    logic [msd_pkg::PC_W-1:0]      r_pc;
    logic [msd_pkg::PC_W-1:0]      n_pc;
    logic [msd_pkg::CNT_W-1:0]     r_cnt;
    msd_pkg::t_uword               uw;

    logic signed [msd_pkg::POS_W-1:0] r_px, r_py, r_pz;
    logic                             r_jump, r_ladder, r_clear;
    logic signed [msd_pkg::POS_W-1:0] r_last_x, r_last_y, r_last_z;
    logic signed [msd_pkg::POS_W-1:0] r_spot_x, r_spot_y, r_spot_z;

    logic [msd_pkg::DIF_W-1:0]   r_dif;
    logic [msd_pkg::PROD_W-1:0]  r_prod;
    logic [msd_pkg::D2_W-1:0]    r_acc;
    logic [msd_pkg::ROOT_W-1:0]  r_root;
    logic [msd_pkg::REM_W-1:0]   r_rem;
    logic [SUM_W-1:0]            r_sum;
    logic [THR_W-1:0]            r_thr;
    logic [IDX_W-1:0]            r_idx;
    logic [FILL_W-1:0]           r_fill;
    logic                        r_full;
    logic                        r_stuck;
    logic                        r_entered;
    logic                        r_left;

    logic                        r_ovalid;
    logic                        r_o_stuck, r_o_entered, r_o_left;

    logic signed [msd_pkg::POS_W-1:0] dif_p, dif_ref;
    logic signed [msd_pkg::DIF_W-1:0] dif_s;
    logic [msd_pkg::DIF_W-1:0]        dif_abs;
    logic [msd_pkg::DIF_W-1:0]        mul_a, mul_b;
    logic [msd_pkg::PROD_W-1:0]       mul_p;
    logic [7:0]                       lim_sel;
    logic [msd_pkg::REM_W+1:0]        sq_tmp;
    logic [msd_pkg::REM_W+1:0]        sq_trial;
    logic                             sq_ge;
    logic [msd_pkg::D2_W-1:0]         r2;
    logic [CMP_W-1:0]                 cmp_sum, cmp_thr;
    logic [msd_pkg::LEN_W-1:0]        len;
    logic [msd_pkg::LEN_W-1:0]        ram_rdata;
    logic                             ram_we, ram_re;
    logic                             in_xfer, fin_go;

    assign uw         = msd_pkg::ucode(r_pc);
    assign o_in_ready = !r_busy;
    assign in_xfer    = i_in_valid && !r_busy;
    assign fin_go     = r_busy && (uw.act == msd_pkg::ACT_FINISH) && (!r_ovalid || i_out_ready);
    assign pready     = 1'b1;

    always_comb begin
        unique case (paddr[3:2])
            msd_pkg::REG_TICK:   prdata = 32'(r_tick);
            msd_pkg::REG_NORMAL: prdata = 32'(r_lim_normal);
            msd_pkg::REG_LADDER: prdata = 32'(r_lim_ladder);
            msd_pkg::REG_RANGE:  prdata = 32'(r_range);
            default:             prdata = '0;
        endcase
    end

    always_comb begin
        unique case (uw.dif_axis)
            msd_pkg::AX_X: begin
                dif_p   = r_px;
                dif_ref = r_stuck ? r_spot_x : r_last_x;
            end
            msd_pkg::AX_Y: begin
                dif_p   = r_py;
                dif_ref = r_stuck ? r_spot_y : r_last_y;
            end
            msd_pkg::AX_Z: begin
                dif_p   = (r_jump && !r_stuck) ? '0 : r_pz;
                dif_ref = (r_jump && !r_stuck) ? '0 : (r_stuck ? r_spot_z : r_last_z);
            end
            default: begin
                dif_p   = '0;
                dif_ref = '0;
            end
        endcase
        dif_s   = msd_pkg::DIF_W'(dif_p) - msd_pkg::DIF_W'(dif_ref);
        dif_abs = dif_s[msd_pkg::DIF_W-1] ? msd_pkg::DIF_W'(-dif_s) : msd_pkg::DIF_W'(dif_s);
    end

    assign lim_sel = r_ladder ? r_lim_ladder : r_lim_normal;

    always_comb begin
        unique case (uw.mul_sel)
            msd_pkg::MS_DIF: begin
                mul_a = r_dif;
                mul_b = r_dif;
            end
            msd_pkg::MS_RANGE: begin
                mul_a = msd_pkg::DIF_W'(r_range);
                mul_b = msd_pkg::DIF_W'(r_range);
            end
            msd_pkg::MS_LIMIT: begin
                mul_a = msd_pkg::DIF_W'(lim_sel);
                mul_b = msd_pkg::DIF_W'(r_tick);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    assign sq_tmp   = {r_rem, r_acc[msd_pkg::D2_W-1 -: 2]};
    assign sq_trial = (msd_pkg::REM_W + 2)'({r_root, 2'b01});
    assign sq_ge    = sq_tmp >= sq_trial;
    assign len      = r_root[msd_pkg::LEN_W-1:0];
    assign r2       = msd_pkg::D2_W'({r_prod[19:0], 16'b0});
    assign cmp_sum  = CMP_W'(r_sum);
    assign cmp_thr  = CMP_W'(r_thr);
    assign ram_re   = r_busy && (uw.act == msd_pkg::ACT_START);
    assign ram_we   = r_busy && (uw.act == msd_pkg::ACT_ADD_NEW);

    always_comb begin
        n_pc = r_pc + msd_pkg::PC_W'(1);
        unique case (uw.jmp_cond)
            msd_pkg::JC_ALWAYS: n_pc = uw.jmp_tgt;
            msd_pkg::JC_CLEAR:  if (r_clear) begin
                n_pc = uw.jmp_tgt;
            end
            msd_pkg::JC_STUCK:  if (r_stuck) begin
                n_pc = uw.jmp_tgt;
            end
            msd_pkg::JC_LOOP:   if (r_cnt != '0) begin
                n_pc = uw.jmp_tgt;
            end
            default: ;
        endcase
    end

    msd_ram #(
        .WIDTH(msd_pkg::LEN_W),
        .DEPTH(SAMPLE_COUNT)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_idx),
        .i_wdata (len),
        .i_re    (ram_re),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick       <= 8'd26;
            r_lim_normal <= 8'd20;
            r_lim_ladder <= 8'd10;
            r_range      <= 10'd75;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                msd_pkg::REG_TICK:   r_tick       <= pwdata[7:0];
                msd_pkg::REG_NORMAL: r_lim_normal <= pwdata[7:0];
                msd_pkg::REG_LADDER: r_lim_ladder <= pwdata[7:0];
                msd_pkg::REG_RANGE:  r_range      <= pwdata[9:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_px      <= i_pos_x;
            r_py      <= i_pos_y;
            r_pz      <= i_pos_z;
            r_jump    <= i_jumping;
            r_ladder  <= i_on_ladder;
            r_clear   <= i_clear_monitor;
            r_entered <= 1'b0;
            r_left    <= 1'b0;
        end
        if (r_busy) begin
            if (uw.dif_axis != msd_pkg::AX_NONE) begin
                r_dif <= dif_abs;
            end
            if (uw.mul_sel != msd_pkg::MS_NONE) begin
                r_prod <= mul_p;
            end
            case (uw.acc_op)
                msd_pkg::AO_CLEAR: r_acc <= '0;
                msd_pkg::AO_ADD:   r_acc <= r_acc + msd_pkg::D2_W'(r_prod);
                default: ;
            endcase
            unique case (uw.act)
                msd_pkg::ACT_SQ_INIT: begin
                    r_root <= '0;
                    r_rem  <= '0;
                end
                msd_pkg::ACT_SQ_STEP: begin
                    r_acc <= r_acc << 2;
                    if (sq_ge) begin
                        r_rem  <= msd_pkg::REM_W'(sq_tmp - sq_trial);
                        r_root <= {r_root[msd_pkg::ROOT_W-2:0], 1'b1};
                    end else begin
                        r_rem  <= msd_pkg::REM_W'(sq_tmp);
                        r_root <= {r_root[msd_pkg::ROOT_W-2:0], 1'b0};
                    end
                end
                msd_pkg::ACT_ADD_NEW: begin
                    r_thr <= THR_W'(32'(r_prod[15:0]) * SAMPLE_COUNT);
                end
                msd_pkg::ACT_DECIDE: begin
                    if (r_full && (cmp_sum < cmp_thr)) begin
                        r_entered <= 1'b1;
                    end
                end
                msd_pkg::ACT_UNSTUCK: begin
                    if (r_acc > r2) begin
                        r_left <= 1'b1;
                    end
                end
                msd_pkg::ACT_CLEAR: begin
                    r_left <= r_stuck;
                end
                default: ;
            endcase
        end
        if (fin_go) begin
            r_o_stuck   <= r_stuck;
            r_o_entered <= r_entered;
            r_o_left    <= r_left;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_pc     <= msd_pkg::PC_START;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
            r_stuck  <= 1'b0;
            r_idx    <= '0;
            r_fill   <= '0;
            r_full   <= 1'b0;
            r_sum    <= '0;
            r_last_x <= '0;
            r_last_y <= '0;
            r_last_z <= '0;
            r_spot_x <= '0;
            r_spot_y <= '0;
            r_spot_z <= '0;
        end else begin
            if (r_ovalid && i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            if (in_xfer) begin
                r_busy <= 1'b1;
                r_pc   <= msd_pkg::PC_START;
            end
            if (r_busy) begin
                if (uw.act != msd_pkg::ACT_FINISH) begin
                    r_pc <= n_pc;
                end
                unique case (uw.act)
                    msd_pkg::ACT_START: begin
                        r_full <= (r_fill >= FILL_W'(SAMPLE_COUNT));
                    end
                    msd_pkg::ACT_SQ_INIT: begin
                        r_cnt <= msd_pkg::CNT_W'(msd_pkg::SQ_STEPS - 1);
                    end
                    msd_pkg::ACT_SQ_STEP: begin
                        if (r_cnt != '0) begin
                            r_cnt <= r_cnt - msd_pkg::CNT_W'(1);
                        end
                    end
                    msd_pkg::ACT_SUB_OLD: begin
                        if (r_full) begin
                            r_sum <= r_sum - SUM_W'(ram_rdata);
                        end
                    end
                    msd_pkg::ACT_ADD_NEW: begin
                        r_sum <= r_sum + SUM_W'(len);
                        r_idx <= (r_idx == IDX_W'(SAMPLE_COUNT - 1)) ? '0
                                                                      : r_idx + IDX_W'(1);
                        if (!r_full) begin
                            r_fill <= r_fill + FILL_W'(1);
                        end
                    end
                    msd_pkg::ACT_DECIDE: begin
                        if (r_full && (cmp_sum < cmp_thr)) begin
                            r_stuck  <= 1'b1;
                            r_spot_x <= r_px;
                            r_spot_y <= r_py;
                            r_spot_z <= r_pz;
                        end
                    end
                    msd_pkg::ACT_UNSTUCK: begin
                        if (r_acc > r2) begin
                            r_stuck <= 1'b0;
                            r_idx   <= '0;
                            r_fill  <= '0;
                            r_sum   <= '0;
                        end
                    end
                    msd_pkg::ACT_CLEAR: begin
                        r_stuck <= 1'b0;
                        r_idx   <= '0;
                        r_fill  <= '0;
                        r_sum   <= '0;
                    end
                    default: ;
                endcase
            end
            if (fin_go) begin
                r_ovalid <= 1'b1;
                r_busy   <= 1'b0;
                r_last_x <= r_px;
                r_last_y <= r_py;
                r_last_z <= r_pz;
            end
        end
    end

    assign o_out_valid      = r_ovalid;
    assign o_stuck          = r_o_stuck;
    assign o_became_stuck   = r_o_entered;
    assign o_became_unstuck = r_o_left;

endmodule

@@ sv/msd_checker.sv @@
`timescale 1ns / 1ps

module msd_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input logic o_out_valid,
    input logic i_out_ready,
    input logic o_stuck,
    input logic o_became_stuck,
    input logic o_became_unstuck
);

    // A result that enters the stuck state must report the flag as set.
    a_entered_sets_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_became_stuck) |-> o_stuck)
        else $error("became_stuck without stuck");

    a_left_clears_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_became_unstuck) |-> !o_stuck)
        else $error("became_unstuck with stuck still set");

    a_no_both_edges: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_became_stuck && o_became_unstuck))
        else $error("entered and left the stuck state in one tick");

    // The sequencer works on one tick at a time.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken while a tick is in work");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_stuck) && $stable(o_became_stuck)
             && $stable(o_became_unstuck)))
        else $error("stalled result changed");

endmodule

bind motion_stall_detector_core msd_checker u_msd_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_ready       (o_in_ready),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_stuck          (o_stuck),
    .o_became_stuck   (o_became_stuck),
    .o_became_unstuck (o_became_unstuck)
);

@@ tb/tb_motion_stall_detector_core.sv @@
`timescale 1ns / 1ps

module tb_motion_stall_detector_core;

    localparam int     DEPTH       = 8;
    localparam int     QUIET_LIMIT = 3000;
    localparam int     HOLD_CYCLES = 300;
    localparam int     PHASES      = 8;
    localparam int     PHASE_TICKS = 244;
    localparam int     DRAIN_WAIT  = 40;
    localparam longint POS_MAX     = 1048575;
    localparam longint POS_MIN     = -1048576;
    localparam longint DEF_RANGE   = 75;

    typedef struct {
        logic signed [msd_pkg::POS_W-1:0] x;
        logic signed [msd_pkg::POS_W-1:0] y;
        logic signed [msd_pkg::POS_W-1:0] z;
        bit                               jump;
        bit                               ladder;
        bit                               clear;
    } t_motion_tick;

    typedef struct {
        bit stuck;
        bit entered;
        bit left;
    } t_stall_status;

    class stall_scoreboard;
        bit [7:0]      tick_q8;
        bit [7:0]      lim_normal;
        bit [7:0]      lim_ladder;
        bit [9:0]      range;
        longint        last_x, last_y, last_z;
        longint        spot_x, spot_y, spot_z;
        longint        ring [DEPTH];
        longint        move_sum;
        int            idx;
        int            fill;
        bit            stuck;
        t_stall_status expected [$];
        int            ticks, checked, errors, entries, exits, clears;

        function new();
            tick_q8    = 26;
            lim_normal = 20;
            lim_ladder = 10;
            range      = DEF_RANGE;
            last_x = 0; last_y = 0; last_z = 0;
            spot_x = 0; spot_y = 0; spot_z = 0;
            empty_ring();
        endfunction

        function void empty_ring();
            stuck    = 1'b0;
            idx      = 0;
            fill     = 0;
            move_sum = 0;
        endfunction

        function void set_reg(logic [1:0] reg_idx, logic [31:0] value);
            case (reg_idx)
                msd_pkg::REG_TICK:   tick_q8    = value[7:0];
                msd_pkg::REG_NORMAL: lim_normal = value[7:0];
                msd_pkg::REG_LADDER: lim_ladder = value[7:0];
                msd_pkg::REG_RANGE:  range      = value[9:0];
                default: ;
            endcase
        endfunction

        function longint floor_sqrt(longint v);
            longint root;
            longint trial;
            root = 0;
            for (int b = 23; b >= 0; b--) begin
                trial = root | (longint'(1) << b);
                if (trial * trial <= v) root = trial;
            end
            return root;
        endfunction

        function void note_tick(t_motion_tick t);
            longint        px, py, pz, dx, dy, dz, d2, len, thr;
            bit            full;
            t_stall_status e;
            px = t.x;
            py = t.y;
            pz = t.z;
            e.entered = 1'b0;
            e.left    = 1'b0;
            ticks++;
            if (t.clear) begin
                clears++;
                e.left = stuck;
                empty_ring();
            end else if (stuck) begin
                dx = px - spot_x;
                dy = py - spot_y;
                dz = pz - spot_z;
                d2 = dx * dx + dy * dy + dz * dz;
                if (d2 > longint'(range) * longint'(range) * 65536) begin
                    empty_ring();
                    e.left = 1'b1;
                end
            end else begin
                dx = px - last_x;
                dy = py - last_y;
                dz = pz - last_z;
                d2 = dx * dx + dy * dy;
                if (!t.jump) d2 += dz * dz;
                len  = floor_sqrt(d2);
                full = (fill >= DEPTH);
                if (full) move_sum -= ring[idx];
                ring[idx] = len;
                move_sum += len;
                idx = (idx + 1) % DEPTH;
                if (!full) begin
                    fill++;
                end else begin
                    thr = longint'(t.ladder ? lim_ladder : lim_normal) * DEPTH
                          * longint'(tick_q8);
                    if (move_sum < thr) begin
                        stuck     = 1'b1;
                        e.entered = 1'b1;
                        spot_x    = px;
                        spot_y    = py;
                        spot_z    = pz;
                    end
                end
            end
            last_x = px;
            last_y = py;
            last_z = pz;
            e.stuck = stuck;
            if (e.entered) entries++;
            if (e.left) exits++;
            expected.push_back(e);
        endfunction

        function void compare_bit(string field, bit exp_v, logic act_v);
            if (exp_v !== act_v) begin
                $display("%0t: %s mismatch: expected %0b, actual %0b",
                         $time, field, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_result(logic s, logic bs, logic bu);
            t_stall_status e;
            if (expected.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual %0b/%0b/%0b",
                         $time, s, bs, bu);
                errors++;
                return;
            end
            e = expected.pop_front();
            checked++;
            compare_bit("stuck", e.stuck, s);
            compare_bit("became_stuck", e.entered, bs);
            compare_bit("became_unstuck", e.left, bu);
        endfunction

        function int pending();
            return expected.size();
        endfunction
    endclass

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             i_in_valid;
    logic                             o_in_ready;
    logic signed [msd_pkg::POS_W-1:0] i_pos_x;
    logic signed [msd_pkg::POS_W-1:0] i_pos_y;
    logic signed [msd_pkg::POS_W-1:0] i_pos_z;
    logic                             i_jumping;
    logic                             i_on_ladder;
    logic                             i_clear_monitor;
    logic                             o_out_valid;
    logic                             i_out_ready;
    logic                             o_stuck;
    logic                             o_became_stuck;
    logic                             o_became_unstuck;
    logic                             psel;
    logic                             penable;
    logic                             pwrite;
    logic [3:0]                       paddr;
    logic [31:0]                      pwdata;
    logic [31:0]                      prdata;
    logic                             pready;

    stall_scoreboard sb = new();
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int rx_hold        = 0;
    int walk_steps [6] = '{0, 16, 64, 200, 400, 1024};

    motion_stall_detector_core #(
        .SAMPLE_COUNT(DEPTH)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_pos_x         (i_pos_x),
        .i_pos_y         (i_pos_y),
        .i_pos_z         (i_pos_z),
        .i_jumping       (i_jumping),
        .i_on_ladder     (i_on_ladder),
        .i_clear_monitor (i_clear_monitor),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_stuck         (o_stuck),
        .o_became_stuck  (o_became_stuck),
        .o_became_unstuck(o_became_unstuck),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic signed [msd_pkg::POS_W-1:0] clamp_pos(longint v);
        if (v > POS_MAX) return POS_MAX[msd_pkg::POS_W-1:0];
        if (v < POS_MIN) return POS_MIN[msd_pkg::POS_W-1:0];
        return v[msd_pkg::POS_W-1:0];
    endfunction

    function automatic longint rand_pos();
        return longint'($urandom_range(2097151)) + POS_MIN;
    endfunction

    function automatic longint jitter(int step);
        return longint'($urandom_range(2 * step)) - step;
    endfunction

    task automatic send_tick(input t_motion_tick t);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_pos_x         <= t.x;
        i_pos_y         <= t.y;
        i_pos_z         <= t.z;
        i_jumping       <= t.jump;
        i_on_ladder     <= t.ladder;
        i_clear_monitor <= t.clear;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_tick(t);
    endtask

    task automatic emit(input longint x, y, z, input bit j, l, c);
        t_motion_tick t;
        t.x      = clamp_pos(x);
        t.y      = clamp_pos(y);
        t.z      = clamp_pos(z);
        t.jump   = j;
        t.ladder = l;
        t.clear  = c;
        send_tick(t);
    endtask

    task automatic write_reg(input logic [1:0] reg_idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_reg(reg_idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Walks from the origin, across the full position range, then fills the ring at rest,
    // gets stuck, probes the exact leave distance, leaves, and gets stuck again.
    task automatic run_directed();
        longint px, py, pz, qx;
        px = 1000;
        py = -2000;
        pz = 300;
        qx = px + DEF_RANGE * 256 + 1;
        emit(256, 0, 0, 0, 0, 0);
        emit(POS_MAX, POS_MAX, POS_MAX, 0, 0, 0);
        emit(POS_MIN, POS_MIN, POS_MIN, 1, 0, 0);
        emit(px, py, pz, 1, 1, 1);
        repeat (DEPTH) emit(px, py, pz, 0, 0, 0);
        emit(px, py, pz, 0, 1, 0);
        emit(px, py, pz + DEF_RANGE * 256, 1, 0, 0);
        emit(qx, py, pz, 0, 0, 0);
        repeat (DEPTH) emit(qx, py, pz, 0, 0, 0);
        emit(qx, py, pz, 0, 0, 0);
        emit(qx, py, pz, 0, 0, 1);
    endtask

    task automatic run_random(input int count);
        int     sent, kind, seg, step, axis;
        longint off, bx, by, bz;
        bit     lad;
        sent = 0;
        while (sent < count) begin
            kind = $urandom_range(99);
            if (sb.stuck && kind < 25) begin
                bx = sb.spot_x;
                by = sb.spot_y;
                bz = sb.spot_z;
                if (kind < 15) begin
                    off = longint'(sb.range) * 256 + $urandom_range(1);
                    if ($urandom_range(1)) off = -off;
                    axis = $urandom_range(2);
                    if (axis == 0) bx += off;
                    else if (axis == 1) by += off;
                    else bz += off;
                    emit(bx, by, bz, $urandom_range(1), $urandom_range(1), 0);
                end else begin
                    emit(rand_pos(), rand_pos(), rand_pos(), $urandom_range(1), 0, 0);
                end
                sent++;
            end else if (kind < 60) begin
                seg  = $urandom_range(24, 8);
                step = walk_steps[$urandom_range(5)];
                lad  = ($urandom_range(9) < 3);
                repeat (seg) begin
                    emit(sb.last_x + jitter(step), sb.last_y + jitter(step),
                         sb.last_z + jitter(step), $urandom_range(4) == 0, lad,
                         $urandom_range(32) == 0);
                    sent++;
                end
            end else if (kind < 75) begin
                seg  = $urandom_range(12, 4);
                step = $urandom_range(40000, 2000);
                repeat (seg) begin
                    emit(sb.last_x + jitter(step), sb.last_y + jitter(step),
                         sb.last_z + jitter(step), $urandom_range(3) == 0,
                         $urandom_range(1), 0);
                    sent++;
                end
            end else if (kind < 85) begin
                emit(rand_pos(), rand_pos(), rand_pos(), $urandom_range(1),
                     $urandom_range(1), 0);
                sent++;
            end else if (kind < 92) begin
                emit(sb.last_x + jitter(64), sb.last_y + jitter(64), sb.last_z + jitter(64),
                     $urandom_range(1), $urandom_range(1), 1);
                sent++;
            end else begin
                emit(rand_pos(), rand_pos(), rand_pos(), $urandom_range(1),
                     $urandom_range(1), $urandom_range(1));
                sent++;
            end
        end
    endtask

    initial begin : result_sink
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                sb.check_result(o_stuck, o_became_stuck, o_became_unstuck);
            end
            if (rx_hold > 0) begin
                rx_hold--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (psel && penable)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("motion_stall_detector_core test failed");
        $finish;
    end

    initial begin : stimulus
        int unsigned cfg_tick   [PHASES] = '{26, 255, 1, 0, 64, 255, 26, 0};
        int unsigned cfg_normal [PHASES] = '{20, 255, 0, 200, 40, 0, 120, 0};
        int unsigned cfg_ladder [PHASES] = '{10, 255, 0, 100, 5, 255, 60, 0};
        int unsigned cfg_range  [PHASES] = '{75, 1023, 0, 10, 300, 1, 40, 0};
        int p;
        i_rst_n         <= 1'b0;
        i_in_valid      <= 1'b0;
        i_pos_x         <= '0;
        i_pos_y         <= '0;
        i_pos_z         <= '0;
        i_jumping       <= 1'b0;
        i_on_ladder     <= 1'b0;
        i_clear_monitor <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        for (p = 0; p < PHASES; p++) begin
            i_in_valid <= 1'b0;
            while (sb.pending() != 0) @(posedge i_clk);
            if (p == PHASES - 1) begin
                cfg_tick[p]   = $urandom_range(255, 1);
                cfg_normal[p] = $urandom_range(255);
                cfg_ladder[p] = $urandom_range(255);
                cfg_range[p]  = $urandom_range(1023);
            end
            write_reg(msd_pkg::REG_TICK, cfg_tick[p]);
            write_reg(msd_pkg::REG_NORMAL, cfg_normal[p]);
            write_reg(msd_pkg::REG_LADDER, cfg_ladder[p]);
            write_reg(msd_pkg::REG_RANGE, cfg_range[p]);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
                default: begin send_idle_pct = 19; recv_stall_pct = 19; end
            endcase
            // Output held off while ticks keep coming, so the core backs up into its input.
            if (p == 0) rx_hold = HOLD_CYCLES;
            run_random(PHASE_TICKS);
        end
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        $display("Sent %0d ticks over %0d register settings: %0d stuck entries, %0d exits, %0d clears.",
                 sb.ticks, PHASES + 1, sb.entries, sb.exits, sb.clears);
        $display("Compared %0d results field by field, %0d mismatches.", sb.checked, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("motion_stall_detector_core test passed");
        end else begin
            $display("motion_stall_detector_core test failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
sv/msd_pkg.sv
sv/msd_ram.sv
sv/motion_stall_detector_core.sv
sv/msd_checker.sv
tb/tb_motion_stall_detector_core.sv
